>>> src/fmpc_pkg.sv
// Shared types and constants for the first-match packet rule classifier.
`default_nettype none

package fmpc_pkg;

    // Default number of rule slots in the table.
    localparam int RULE_SLOTS_DEF = 64;

    // Fixed field widths.
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int WORD_W  = 32;
    localparam int PROTO_W = 8;
    localparam int HOOK_W  = 5;
    localparam int RIDX_W  = 6;
    localparam int MODE_W  = 2;
    localparam int VERD_W  = 2;

    // Protocol numbers that carry ports.
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // Item kinds.
    typedef enum logic [MODE_W-1:0] {
        MODE_WR_ADDR  = 2'd0,
        MODE_WR_RULE  = 2'd1,
        MODE_CLASSIFY = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    // Verdict codes.
    typedef enum logic [VERD_W-1:0] {
        VERD_NONE   = 2'd0,
        VERD_ACCEPT = 2'd1,
        VERD_DROP   = 2'd2,
        VERD_ACK    = 2'd3
    } verdict_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_SCAN   = 2'd2,
        ST_RESULT = 2'd3
    } state_t;

    // Address half of a rule.
    typedef struct packed {
        logic [IP_W-1:0] src_addr;
        logic [IP_W-1:0] src_mask;
        logic [IP_W-1:0] dst_addr;
        logic [IP_W-1:0] dst_mask;
    } addr_row_t;

    // Port, protocol and action half of a rule.
    typedef struct packed {
        logic               valid;
        logic               accept;
        logic [HOOK_W-1:0]  hooks;
        logic [PROTO_W-1:0] proto;
        logic [WORD_W-1:0]  src_range;
        logic [WORD_W-1:0]  dst_range;
    } rule_row_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_en;
        logic rd_en;
        logic eval_en;
        logic wr_addr_half;
        logic wr_rule_half;
        logic latch_pkt;
        logic res_ack;
        logic res_zero;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic last;
    } status_t;

endpackage

`default_nettype wire

>>> src/fmpc_datapath.sv
// Rule memories, packet registers, match logic and result registers.
`default_nettype none

module fmpc_datapath
    import fmpc_pkg::*;
#(
    parameter int RULE_SLOTS = RULE_SLOTS_DEF,
    parameter int IDX_W      = 6
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    input  wire logic [IDX_W-1:0]     slot_addr,
    output status_t                   status,
    input  wire logic [RIDX_W-1:0]    rule_index,
    input  wire logic [IP_W-1:0]      src_addr,
    input  wire logic [IP_W-1:0]      src_mask,
    input  wire logic [IP_W-1:0]      dst_addr,
    input  wire logic [IP_W-1:0]      dst_mask,
    input  wire logic [WORD_W-1:0]    src_port_word,
    input  wire logic [WORD_W-1:0]    dst_port_word,
    input  wire logic [PROTO_W-1:0]   protocol,
    input  wire logic [HOOK_W-1:0]    hook_mask,
    input  wire logic                 accept_action,
    input  wire logic                 rule_valid,
    output logic [VERD_W-1:0]         verdict,
    output logic [RIDX_W-1:0]         hit_index
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_SLOTS - 1);

    addr_row_t addr_mem [RULE_SLOTS];
    rule_row_t rule_mem [RULE_SLOTS];

    addr_row_t          addr_rd_reg;
    rule_row_t          rule_rd_reg;
    logic               eval_vld_reg;
    logic [IDX_W-1:0]   eval_idx_reg;

    logic [IP_W-1:0]    pkt_src_reg;
    logic [IP_W-1:0]    pkt_dst_reg;
    logic [PORT_W-1:0]  pkt_sport_reg;
    logic [PORT_W-1:0]  pkt_dport_reg;
    logic [PROTO_W-1:0] pkt_proto_reg;
    logic [HOOK_W-1:0]  pkt_hook_reg;

    verdict_t           res_verdict_reg;
    logic [RIDX_W-1:0]  res_idx_reg;
    logic [VERD_W-1:0]  verdict_reg;
    logic [RIDX_W-1:0]  hit_index_reg;

    logic [IDX_W-1:0]   wr_slot;
    logic               slot_ok;
    logic               has_ports;
    addr_row_t          wr_addr_row;
    rule_row_t          wr_rule_row;
    logic               src_ok;
    logic               dst_ok;
    logic               sport_ok;
    logic               dport_ok;
    logic               proto_ok;
    logic               hook_ok;
    logic               hit;

    // Write slot decode; slots beyond the table are acknowledged but not stored.
    assign wr_slot   = IDX_W'(rule_index);
    assign slot_ok   = (32'(rule_index) < RULE_SLOTS);
    assign has_ports = (protocol == PROTO_TCP) || (protocol == PROTO_UDP);

    always_comb
    begin
        wr_addr_row.src_addr  = src_addr;
        wr_addr_row.src_mask  = src_mask;
        wr_addr_row.dst_addr  = dst_addr;
        wr_addr_row.dst_mask  = dst_mask;
        wr_rule_row.valid     = rule_valid;
        wr_rule_row.accept    = accept_action;
        wr_rule_row.hooks     = hook_mask;
        wr_rule_row.proto     = protocol;
        wr_rule_row.src_range = src_port_word;
        wr_rule_row.dst_range = dst_port_word;
    end

    // Address half memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_addr_half && slot_ok)
        begin
            addr_mem[wr_slot] <= wr_addr_row;
        end
        if (cmd.rd_en)
        begin
            addr_rd_reg <= addr_mem[slot_addr];
        end
    end

    // Rule half memory: cleared slot by slot after reset, then written by items.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            rule_mem[slot_addr] <= '0;
        end
        else if (cmd.wr_rule_half && slot_ok)
        begin
            rule_mem[wr_slot] <= wr_rule_row;
        end
        if (cmd.rd_en)
        begin
            rule_rd_reg <= rule_mem[slot_addr];
        end
    end

    // Tracks which slot the registered read data belongs to.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_vld_reg <= 1'b0;
        end
        else
        begin
            eval_vld_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            eval_idx_reg <= slot_addr;
        end
    end

    // Packet fields; ports count only for TCP and UDP.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_pkt)
        begin
            pkt_src_reg   <= src_addr;
            pkt_dst_reg   <= dst_addr;
            pkt_sport_reg <= has_ports ? src_port_word[PORT_W-1:0] : '0;
            pkt_dport_reg <= has_ports ? dst_port_word[PORT_W-1:0] : '0;
            pkt_proto_reg <= protocol;
            pkt_hook_reg  <= hook_mask;
        end
    end

    // Match test of the rule read in the previous cycle.
    always_comb
    begin
        hook_ok  = (rule_rd_reg.hooks & pkt_hook_reg) != '0;
        src_ok   = ((pkt_src_reg & addr_rd_reg.src_mask) ==
                    (addr_rd_reg.src_addr & addr_rd_reg.src_mask)) ||
                   (addr_rd_reg.src_addr == '0) ||
                   (pkt_src_reg == addr_rd_reg.src_addr);
        dst_ok   = (pkt_dst_reg == addr_rd_reg.dst_addr) ||
                   ((pkt_dst_reg & addr_rd_reg.dst_mask) ==
                    (addr_rd_reg.dst_addr & addr_rd_reg.dst_mask));
        sport_ok = (pkt_sport_reg >= rule_rd_reg.src_range[WORD_W-1:PORT_W]) &&
                   (pkt_sport_reg <= rule_rd_reg.src_range[PORT_W-1:0]);
        dport_ok = (pkt_dport_reg >= rule_rd_reg.dst_range[WORD_W-1:PORT_W]) &&
                   (pkt_dport_reg <= rule_rd_reg.dst_range[PORT_W-1:0]);
        proto_ok = (rule_rd_reg.proto == '0) || (rule_rd_reg.proto == pkt_proto_reg);
        hit      = eval_vld_reg && rule_rd_reg.valid && hook_ok && src_ok && dst_ok &&
                   sport_ok && dport_ok && proto_ok;
    end

    assign status.hit  = hit;
    assign status.last = eval_vld_reg && (eval_idx_reg == LAST_IDX);

    // Pending result: acknowledge, no match, or the first hit of a scan.
    always_ff @(posedge clk)
    begin
        if (cmd.res_ack)
        begin
            res_verdict_reg <= VERD_ACK;
            res_idx_reg     <= rule_index;
        end
        else if (cmd.res_zero)
        begin
            res_verdict_reg <= VERD_NONE;
            res_idx_reg     <= '0;
        end
        else if (cmd.eval_en && hit)
        begin
            res_verdict_reg <= rule_rd_reg.accept ? VERD_ACCEPT : VERD_DROP;
            res_idx_reg     <= RIDX_W'(eval_idx_reg);
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            verdict_reg   <= res_verdict_reg;
            hit_index_reg <= res_idx_reg;
        end
    end

    assign verdict   = verdict_reg;
    assign hit_index = hit_index_reg;

`ifndef ASSERT_OFF
    // The evaluated slot is always the one read in the cycle before.
    a_eval_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> (eval_vld_reg && (eval_idx_reg == $past(slot_addr))))
        else $error("evaluated slot does not match the read address");
`endif

endmodule

`default_nettype wire

>>> src/fmpc_ctrl.sv
// Controller state machine: table clearing, item decode, rule scan and result hand-off.
`default_nettype none

module fmpc_ctrl
    import fmpc_pkg::*;
#(
    parameter int RULE_SLOTS = RULE_SLOTS_DEF,
    parameter int IDX_W      = 6
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [MODE_W-1:0]  mode,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire status_t            status,
    output cmd_t                    cmd,
    output logic [IDX_W-1:0]        slot_addr
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_SLOTS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             issued_all_reg;
    logic             issued_all_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             out_free;
    mode_t            item_mode;

    assign item_mode = mode_t'(mode);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (item_mode == MODE_CLASSIFY) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (status.hit || status.last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (item_mode)
                        MODE_WR_ADDR:
                        begin
                            cmd.wr_addr_half = 1'b1;
                            cmd.res_ack      = 1'b1;
                        end
                        MODE_WR_RULE:
                        begin
                            cmd.wr_rule_half = 1'b1;
                            cmd.res_ack      = 1'b1;
                        end
                        MODE_CLASSIFY:
                        begin
                            cmd.latch_pkt = 1'b1;
                            cmd.res_zero  = 1'b1;
                        end
                        default:
                        begin
                            cmd.res_zero = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.eval_en = 1'b1;
                cmd.rd_en   = !issued_all_reg && !status.hit;
            end
            ST_RESULT:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Slot counter, scan progress and output valid.
    always_comb
    begin
        cnt_next        = cnt_reg;
        issued_all_next = issued_all_reg;
        if (state_reg == ST_CLEAR)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (accept)
        begin
            cnt_next        = '0;
            issued_all_next = 1'b0;
        end
        else if (cmd.rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_IDX)
            begin
                issued_all_next = 1'b1;
            end
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            issued_all_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            issued_all_reg <= issued_all_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign slot_addr = cnt_reg;
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    // The clearing pass runs once after reset and never again.
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("rule table clearing re-entered");

    // A hit ends the scan at once.
    a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && status.hit) |=> (state_reg == ST_RESULT))
        else $error("scan continued past the first hit");

    // A finished item with a free output slot is presented in the next cycle.
    a_result_presented: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RESULT) && !out_valid_reg) |=> out_valid_reg)
        else $error("result not presented");
`endif

endmodule

`default_nettype wire

>>> src/first_match_packet_rule_classifier_unit.sv
// Top level of the first-match packet rule classifier.
//
//  Channel  Handshake              Contents
//  in       in_valid / in_ready    mode, rule_index, addresses, masks, port words,
//                                  protocol, hook_mask, accept_action, rule_valid
//  out      out_valid / out_ready  verdict, hit_index
//
// A write or unused-mode item goes through the result state into the output register;
// the next item can be accepted once the controller is idle again.
// A classify item reads the rule memories from slot 0 upwards, one registered read
// per slot, and stops at the first hit or after the last slot; its result then goes
// through the result state into the output register like any other.
// After reset the rule half of every slot is cleared, one slot a cycle, during which
// no item is accepted.
// The output register lets the next item be accepted while a result waits; a second
// finished result is held until the first has been taken.
`default_nettype none

module first_match_packet_rule_classifier_unit
    import fmpc_pkg::*;
#(
    parameter int RULE_SLOTS = RULE_SLOTS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [MODE_W-1:0]    mode,
    input  wire logic [RIDX_W-1:0]    rule_index,
    input  wire logic [IP_W-1:0]      src_addr,
    input  wire logic [IP_W-1:0]      src_mask,
    input  wire logic [IP_W-1:0]      dst_addr,
    input  wire logic [IP_W-1:0]      dst_mask,
    input  wire logic [WORD_W-1:0]    src_port_word,
    input  wire logic [WORD_W-1:0]    dst_port_word,
    input  wire logic [PROTO_W-1:0]   protocol,
    input  wire logic [HOOK_W-1:0]    hook_mask,
    input  wire logic                 accept_action,
    input  wire logic                 rule_valid,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [VERD_W-1:0]         verdict,
    output logic [RIDX_W-1:0]         hit_index
);

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    cmd_t             cmd;
    status_t          status;
    logic [IDX_W-1:0] slot_addr;

    // Sequencer.
    fmpc_ctrl #(
        .RULE_SLOTS (RULE_SLOTS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .cmd        (cmd),
        .slot_addr  (slot_addr)
    );

    // Rule storage and match logic.
    fmpc_datapath #(
        .RULE_SLOTS (RULE_SLOTS),
        .IDX_W      (IDX_W)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .slot_addr      (slot_addr),
        .status         (status),
        .rule_index     (rule_index),
        .src_addr       (src_addr),
        .src_mask       (src_mask),
        .dst_addr       (dst_addr),
        .dst_mask       (dst_mask),
        .src_port_word  (src_port_word),
        .dst_port_word  (dst_port_word),
        .protocol       (protocol),
        .hook_mask      (hook_mask),
        .accept_action  (accept_action),
        .rule_valid     (rule_valid),
        .verdict        (verdict),
        .hit_index      (hit_index)
    );

endmodule

`default_nettype wire
